// ----- hw/rtl/qpr_pkg.sv -----
// qpr_pkg: shared types and constants for the quaternion product / rotate unit
// no dependencies

package qpr_pkg;

  // component width of every input and output quaternion field
  localparam int DATA_W = 16;

  // width of a first-level Hamilton sum: 16x16 product plus two growth bits
  localparam int H1_W = 2 * DATA_W + 2;

  // width of a negated conjugate component (holds +32768)
  localparam int AC_W = DATA_W + 1;

  // width of a second-level Hamilton sum
  localparam int H2_W = H1_W + AC_W + 2;

  typedef logic signed [DATA_W-1:0] comp_t;

  // operation select codes
  localparam logic FUNC_PRODUCT = 1'b0;
  localparam logic FUNC_ROTATE  = 1'b1;

  // output saturation limits
  localparam comp_t OUT_MAX = 16'sh7fff;
  localparam comp_t OUT_MIN = -16'sh8000;

endpackage

// ----- hw/rtl/qpr_hamilton.sv -----
// qpr_hamilton: two-stage Hamilton product r = p * q (products, then sums)
// depends on nothing; widths are set by parameters

module qpr_hamilton #(
  parameter int P_W = 16,
  parameter int Q_W = 16
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [P_W-1:0]      p [4],
  input  logic signed [Q_W-1:0]      q [4],
  output logic signed [P_W+Q_W+1:0]  r [4]
);

  localparam int PROD_W = P_W + Q_W;
  localparam int SUM_W  = PROD_W + 2;

  logic signed [PROD_W-1:0] prod [4][4];

  // sign extend one product to the sum width
  function automatic logic signed [SUM_W-1:0] sx(input logic signed [PROD_W-1:0] x);
    logic signed [SUM_W-1:0] y;
    y = SUM_W'(x);
    return y;
  endfunction

  // stage a: all sixteen cross products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          prod[i][j] <= p[i] * q[j];
        end
      end
    end
  end

  // stage b: signed combination of the products per component
  always_ff @(posedge clk) begin
    if (en) begin
      r[0] <= sx(prod[0][0]) - sx(prod[1][1]) - sx(prod[2][2]) - sx(prod[3][3]);
      r[1] <= sx(prod[0][1]) + sx(prod[1][0]) + sx(prod[2][3]) - sx(prod[3][2]);
      r[2] <= sx(prod[0][2]) - sx(prod[1][3]) + sx(prod[2][0]) + sx(prod[3][1]);
      r[3] <= sx(prod[0][3]) + sx(prod[1][2]) - sx(prod[2][1]) + sx(prod[3][0]);
    end
  end

endmodule

// ----- hw/rtl/qpr_round.sv -----
// qpr_round: round-to-nearest by the fixed-point scale, saturate to 16 bits
// depends on qpr_pkg

module qpr_round #(
  parameter int FRAC_BITS = 14,
  parameter int IN_W      = 53
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic                   func,
  input  logic signed [IN_W-1:0] v [4],
  output qpr_pkg::comp_t         r [4],
  output logic                   sat
);

  localparam int ROUND_W = (IN_W + 1 > 3 * FRAC_BITS + 2) ? IN_W + 1 : 3 * FRAC_BITS + 2;
  localparam int SH2     = 2 * FRAC_BITS;
  localparam int SH3     = 3 * FRAC_BITS;
  localparam logic signed [ROUND_W-1:0] HALF2 = ROUND_W'(1) <<< (SH2 - 1);
  localparam logic signed [ROUND_W-1:0] HALF3 = ROUND_W'(1) <<< (SH3 - 1);

  logic signed [ROUND_W-1:0] lim_hi;
  logic signed [ROUND_W-1:0] lim_lo;
  qpr_pkg::comp_t            r_next [4];
  logic                      sat_next;

  assign lim_hi = ROUND_W'(qpr_pkg::OUT_MAX);
  assign lim_lo = ROUND_W'(qpr_pkg::OUT_MIN);

  // per-lane rounding and clipping
  always_comb begin
    logic signed [ROUND_W-1:0] ext;
    logic signed [ROUND_W-1:0] q2;
    logic signed [ROUND_W-1:0] q3;
    logic signed [ROUND_W-1:0] qs;
    sat_next = 1'b0;
    for (int i = 0; i < 4; i++) begin
      ext = ROUND_W'(v[i]);
      q2  = (ext + HALF2) >>> SH2;
      q3  = (ext + HALF3) >>> SH3;
      qs  = (func == qpr_pkg::FUNC_ROTATE) ? q3 : q2;
      if (qs > lim_hi) begin
        r_next[i] = qpr_pkg::OUT_MAX;
        sat_next  = 1'b1;
      end else if (qs < lim_lo) begin
        r_next[i] = qpr_pkg::OUT_MIN;
        sat_next  = 1'b1;
      end else begin
        r_next[i] = qs[qpr_pkg::DATA_W-1:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      r   <= r_next;
      sat <= sat_next;
    end
  end

endmodule

// ----- hw/rtl/quaternion_product_rotate_unit_core.sv -----
// quaternion_product_rotate_unit_core: Hamilton product A*B or rotation A*(0,v)*conj(A)
// one item per cycle sustained while no finished result is held at the output
// five register stages: two per chained Hamilton unit plus the rounding stage
// a stall on the output freezes the whole pipeline; no bubbles are lost or repeated
// synchronous active-high reset clears all stage valid bits; data registers are not reset
// depends on qpr_pkg, qpr_hamilton, qpr_round

module quaternion_product_rotate_unit_core #(
  parameter int FRAC_BITS = 14
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           func,
  input  qpr_pkg::comp_t a_w,
  input  qpr_pkg::comp_t a_x,
  input  qpr_pkg::comp_t a_y,
  input  qpr_pkg::comp_t a_z,
  input  qpr_pkg::comp_t b_w,
  input  qpr_pkg::comp_t b_x,
  input  qpr_pkg::comp_t b_y,
  input  qpr_pkg::comp_t b_z,
  output logic           out_valid,
  input  logic           out_stall,
  output qpr_pkg::comp_t r_w,
  output qpr_pkg::comp_t r_x,
  output qpr_pkg::comp_t r_y,
  output qpr_pkg::comp_t r_z,
  output logic           saturated
);

  localparam int H1_W = qpr_pkg::H1_W;
  localparam int AC_W = qpr_pkg::AC_W;
  localparam int H2_W = qpr_pkg::H2_W;

  logic                   en;
  logic [4:0]             vld;
  logic                   func_d1, func_d2, func_d3, func_d4, func_o;
  qpr_pkg::comp_t         a_in  [4];
  qpr_pkg::comp_t         b_in  [4];
  qpr_pkg::comp_t         a_d1  [4];
  qpr_pkg::comp_t         a_d2  [4];
  logic signed [AC_W-1:0] ac    [4];
  logic signed [H1_W-1:0] h1    [4];
  logic signed [H1_W-1:0] h_d1  [4];
  logic signed [H1_W-1:0] h_d2  [4];
  logic signed [H2_W-1:0] h2    [4];
  logic signed [H2_W-1:0] sel   [4];
  qpr_pkg::comp_t         r_out [4];

  // pipeline advances unless a finished result is held by the receiver
  assign en        = !(vld[4] && out_stall);
  assign in_stall  = vld[4] && out_stall;
  assign out_valid = vld[4];

  // operand gathering; rotate uses a pure vector for B
  assign a_in[0] = a_w;
  assign a_in[1] = a_x;
  assign a_in[2] = a_y;
  assign a_in[3] = a_z;
  assign b_in[0] = (func == qpr_pkg::FUNC_ROTATE) ? '0 : b_w;
  assign b_in[1] = b_x;
  assign b_in[2] = b_y;
  assign b_in[3] = b_z;

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:0], in_valid};
    end
  end

  // sideband delay lines
  always_ff @(posedge clk) begin
    if (en) begin
      func_d1 <= func;
      func_d2 <= func_d1;
      func_d3 <= func_d2;
      func_d4 <= func_d3;
      func_o  <= func_d4;
      a_d1    <= a_in;
      a_d2    <= a_d1;
      h_d1    <= h1;
      h_d2    <= h_d1;
    end
  end

  // conjugate of A, widened so that negating the most negative value is exact
  always_comb begin
    ac[0] = AC_W'(a_d2[0]);
    for (int i = 1; i < 4; i++) begin
      ac[i] = -{a_d2[i][qpr_pkg::DATA_W-1], a_d2[i]};
    end
  end

  // first product: A*B, or A*(0,v) for rotate
  qpr_hamilton #(
    .P_W(qpr_pkg::DATA_W),
    .Q_W(qpr_pkg::DATA_W)
  ) u_ham1 (
    .clk(clk),
    .en (en),
    .p  (a_in),
    .q  (b_in),
    .r  (h1)
  );

  // second product: (A*(0,v)) * conj(A)
  qpr_hamilton #(
    .P_W(H1_W),
    .Q_W(AC_W)
  ) u_ham2 (
    .clk(clk),
    .en (en),
    .p  (h1),
    .q  (ac),
    .r  (h2)
  );

  // choose the exact result for the operation
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sel[i] = (func_d4 == qpr_pkg::FUNC_ROTATE) ? h2[i] : H2_W'(h_d2[i]);
    end
  end

  // rounding, saturation and output register
  qpr_round #(
    .FRAC_BITS(FRAC_BITS),
    .IN_W     (H2_W)
  ) u_round (
    .clk (clk),
    .en  (en),
    .func(func_d4),
    .v   (sel),
    .r   (r_out),
    .sat (saturated)
  );

  assign r_w = r_out[0];
  assign r_x = r_out[1];
  assign r_y = r_out[2];
  assign r_z = r_out[3];

  // input is only held off while a result waits at the output
  assert property (@(posedge clk) disable iff (rst) in_stall |-> out_valid)
    else $error("input stalled without a pending result");

  // an input transfer always lands in the first stage
  assert property (@(posedge clk) disable iff (rst) (in_valid && !in_stall) |=> vld[0])
    else $error("accepted transfer lost at stage one");

  // a held result freezes every stage valid bit
  assert property (@(posedge clk) disable iff (rst) (out_valid && out_stall) |=> $stable(vld))
    else $error("pipeline moved during output stall");

  // rotating a pure vector always yields a zero scalar part
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && func_o == qpr_pkg::FUNC_ROTATE) |-> (r_w == '0))
    else $error("rotate produced nonzero scalar part");

endmodule

// ----- sim/tb_quaternion_product_rotate_unit_core.sv -----
// tb_quaternion_product_rotate_unit_core: checks Hamilton product and vector rotation results
// against a fixed-point predictor, with random sender bursts and receiver stalls
// depends on qpr_pkg and quaternion_product_rotate_unit_core

module tb_quaternion_product_rotate_unit_core;

  localparam int FRAC = 14;
  localparam int N_RANDOM = 700;
  localparam int IDLE_LIMIT = 1000;
  localparam int HOLD_CYCLES = 120;
  localparam int HOLD_AFTER = 250;
  localparam int DRAIN_CYCLES = 12;

  typedef struct packed {
    logic  fn;
    qpr_pkg::comp_t aw, ax, ay, az;
    qpr_pkg::comp_t bw, bx, by, bz;
  } qop_t;

  typedef struct packed {
    qpr_pkg::comp_t rw, rx, ry, rz;
    logic  sat;
  } qres_t;

  typedef struct packed {
    longint w, x, y, z;
  } quat_t;

  typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

  logic  clk;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_stall;
  logic  func = qpr_pkg::FUNC_PRODUCT;
  qpr_pkg::comp_t a_w = '0, a_x = '0, a_y = '0, a_z = '0;
  qpr_pkg::comp_t b_w = '0, b_x = '0, b_y = '0, b_z = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  qpr_pkg::comp_t r_w, r_x, r_y, r_z;
  logic  saturated;

  qop_t  op_q[$];
  qres_t quat_due_q[$];
  int    errs = 0;
  int    n_in = 0, n_out = 0, n_rot = 0, n_sat = 0;
  int    idle_cycles = 0;

  quaternion_product_rotate_unit_core #(.FRAC_BITS(FRAC)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func),
    .a_w(a_w), .a_x(a_x), .a_y(a_y), .a_z(a_z),
    .b_w(b_w), .b_x(b_x), .b_y(b_y), .b_z(b_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .r_w(r_w), .r_x(r_x), .r_y(r_y), .r_z(r_z),
    .saturated(saturated)
  );

  // exact Hamilton product p*q
  function automatic quat_t hmul(quat_t p, quat_t q);
    longint p0, p1, p2, p3, q0, q1, q2, q3;
    quat_t r;
    p0 = p.w; p1 = p.x; p2 = p.y; p3 = p.z;
    q0 = q.w; q1 = q.x; q2 = q.y; q3 = q.z;
    r.w = p0 * q0 - p1 * q1 - p2 * q2 - p3 * q3;
    r.x = p0 * q1 + p1 * q0 + p2 * q3 - p3 * q2;
    r.y = p0 * q2 - p1 * q3 + p2 * q0 + p3 * q1;
    r.z = p0 * q3 + p1 * q2 - p2 * q1 + p3 * q0;
    return r;
  endfunction

  // round to nearest with ties up, then clip to the 16-bit range
  function automatic qpr_pkg::comp_t round_sat(input longint v, input int sh,
                                               output logic clipped);
    longint half, q;
    half = 1;
    half = half << (sh - 1);
    q = (v + half) >>> sh;
    clipped = 1'b0;
    if (q > 32767) begin
      clipped = 1'b1;
      q = 32767;
    end else if (q < -32768) begin
      clipped = 1'b1;
      q = -32768;
    end
    return qpr_pkg::comp_t'(q[15:0]);
  endfunction

  // expected result of one quaternion operation
  function automatic qres_t quat_eval(qop_t op);
    quat_t a, b, t, ac, r;
    int sh;
    logic c0, c1, c2, c3;
    qres_t res;
    a.w = op.aw; a.x = op.ax; a.y = op.ay; a.z = op.az;
    b.w = op.bw; b.x = op.bx; b.y = op.by; b.z = op.bz;
    if (op.fn == qpr_pkg::FUNC_PRODUCT) begin
      r = hmul(a, b);
      sh = 2 * FRAC;
    end else begin
      // rotation: scalar of the vector is dropped, conj(A) on the right
      b.w = 0;
      ac.w = a.w; ac.x = -a.x; ac.y = -a.y; ac.z = -a.z;
      t = hmul(a, b);
      r = hmul(t, ac);
      sh = 3 * FRAC;
    end
    res.rw = round_sat(r.w, sh, c0);
    res.rx = round_sat(r.x, sh, c1);
    res.ry = round_sat(r.y, sh, c2);
    res.rz = round_sat(r.z, sh, c3);
    res.sat = c0 | c1 | c2 | c3;
    return res;
  endfunction

  function automatic void queue_op(logic fn,
                                   qpr_pkg::comp_t aw, qpr_pkg::comp_t ax,
                                   qpr_pkg::comp_t ay, qpr_pkg::comp_t az,
                                   qpr_pkg::comp_t bw, qpr_pkg::comp_t bx,
                                   qpr_pkg::comp_t by, qpr_pkg::comp_t bz);
    qop_t op;
    op.fn = fn;
    op.aw = aw; op.ax = ax; op.ay = ay; op.az = az;
    op.bw = bw; op.bx = bx; op.by = by; op.bz = bz;
    op_q.push_back(op);
  endfunction

  // component value: full range, near unit magnitude, or a corner
  function automatic qpr_pkg::comp_t pick_comp(int style);
    qpr_pkg::comp_t v;
    if (style == 0) begin
      v = qpr_pkg::comp_t'($urandom);
    end else if (style == 1) begin
      v = qpr_pkg::comp_t'($urandom_range(0, 32768) - 16384);
    end else begin
      case ($urandom_range(0, 7))
        0: v = 16'sh7fff;
        1: v = -16'sh8000;
        2: v = 16'sh4000;
        3: v = -16'sh4000;
        4: v = 16'sh0001;
        5: v = -16'sh0001;
        6: v = 16'sh0000;
        default: v = qpr_pkg::comp_t'($urandom);
      endcase
    end
    return v;
  endfunction

  function automatic qop_t rand_op();
    qop_t op;
    int style;
    style = $urandom_range(0, 9);
    style = (style < 4) ? 0 : (style < 8) ? 1 : 2;
    op.fn = $urandom_range(0, 1) ? qpr_pkg::FUNC_ROTATE : qpr_pkg::FUNC_PRODUCT;
    op.aw = pick_comp(style); op.ax = pick_comp(style);
    op.ay = pick_comp(style); op.az = pick_comp(style);
    op.bw = pick_comp(style); op.bx = pick_comp(style);
    op.by = pick_comp(style); op.bz = pick_comp(style);
    return op;
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // input driver: bursts of offered items separated by random gaps
  always @(posedge clk) begin : drv
    qop_t cur_op;
    int burst_left, gap_left;
    logic take;
    if (rst) begin
      in_valid <= 1'b0;
      burst_left = $urandom_range(1, 30);
      gap_left = 0;
    end else begin
      take = in_valid && !in_stall;
      if (take) begin
        quat_due_q.push_back(quat_eval(cur_op));
        n_in++;
        if (cur_op.fn == qpr_pkg::FUNC_ROTATE) n_rot++;
      end
      if (in_valid && !take) begin
        // stalled transfer: payload holds
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (op_q.size() > 0) begin
        cur_op = op_q.pop_front();
        func <= cur_op.fn;
        a_w <= cur_op.aw; a_x <= cur_op.ax; a_y <= cur_op.ay; a_z <= cur_op.az;
        b_w <= cur_op.bw; b_x <= cur_op.bx; b_y <= cur_op.by; b_z <= cur_op.bz;
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 30);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output monitor and receiver stall pattern
  always @(posedge clk) begin : mon
    qres_t want;
    rx_mode_t rx_mode;
    int run_left, hold_left;
    logic hold_done;
    if (rst) begin
      out_stall <= 1'b0;
      rx_mode = RX_FREE;
      run_left = 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      // compare each output transfer with the oldest prediction
      if (out_valid && !out_stall) begin
        n_out++;
        if (saturated) n_sat++;
        if (quat_due_q.size() == 0) begin
          $error("output transfer with no prediction pending");
          errs++;
        end else begin
          want = quat_due_q.pop_front();
          if (r_w !== want.rw) begin
            $error("r_w expected %0d actual %0d", want.rw, r_w);
            errs++;
          end
          if (r_x !== want.rx) begin
            $error("r_x expected %0d actual %0d", want.rx, r_x);
            errs++;
          end
          if (r_y !== want.ry) begin
            $error("r_y expected %0d actual %0d", want.ry, r_y);
            errs++;
          end
          if (r_z !== want.rz) begin
            $error("r_z expected %0d actual %0d", want.rz, r_z);
            errs++;
          end
          if (saturated !== want.sat) begin
            $error("saturated expected %0b actual %0b", want.sat, saturated);
            errs++;
          end
        end
      end
      // one long hold-off so the pipeline fills and backs up the input
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && n_out >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        if (run_left == 0) begin
          rx_mode = rx_mode_t'($urandom_range(0, 3));
          run_left = $urandom_range(10, 60);
        end else begin
          run_left--;
        end
        case (rx_mode)
          RX_FREE:  out_stall <= 1'b0;
          RX_LIGHT: out_stall <= ($urandom_range(0, 9) < 3);
          RX_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
          default:  out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("no transfer for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, quat_due_q.size());
      $display("quaternion_product_rotate_unit_core: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus, reset and end of run
  initial begin : main
    int n_total;
    // directed: zeros, identity, extremes, rounding ties, basis products
    queue_op(qpr_pkg::FUNC_PRODUCT, 0, 0, 0, 0, 0, 0, 0, 0);
    queue_op(qpr_pkg::FUNC_PRODUCT, 16384, 0, 0, 0, 1234, -5678, 9000, -32768);
    queue_op(qpr_pkg::FUNC_PRODUCT, 32767, 32767, 32767, 32767,
             32767, 32767, 32767, 32767);
    queue_op(qpr_pkg::FUNC_PRODUCT, -32768, -32768, -32768, -32768,
             -32768, -32768, -32768, -32768);
    queue_op(qpr_pkg::FUNC_PRODUCT, -32768, -32768, -32768, -32768,
             32767, 32767, 32767, 32767);
    // positive tie rounds up, negative tie rounds toward zero, just under a tie
    queue_op(qpr_pkg::FUNC_PRODUCT, 8192, 0, 0, 0, 16384, 0, 0, 0);
    queue_op(qpr_pkg::FUNC_PRODUCT, -8192, 0, 0, 0, 16384, 0, 0, 0);
    queue_op(qpr_pkg::FUNC_PRODUCT, 8191, 0, 0, 0, 16384, 0, 0, 0);
    queue_op(qpr_pkg::FUNC_PRODUCT, 0, 16384, 0, 0, 0, 0, 16384, 0);
    queue_op(qpr_pkg::FUNC_PRODUCT, 16'sh5555, -16'sh5556, 16'sh5555, -16'sh5556,
             -16'sh5556, 16'sh5555, -16'sh5556, 16'sh5555);
    // rotation: identity ignores b_w, ties on the vector, quarter turn about z
    queue_op(qpr_pkg::FUNC_ROTATE, 16384, 0, 0, 0, 32767, 1000, -2000, 32767);
    queue_op(qpr_pkg::FUNC_ROTATE, 16384, 0, 0, 0, -32768, 8192, -8192, 1);
    queue_op(qpr_pkg::FUNC_ROTATE, 11585, 0, 0, 11585, 0, 16384, 0, 0);
    queue_op(qpr_pkg::FUNC_ROTATE, 32767, 32767, 32767, 32767,
             32767, 32767, 32767, 32767);
    queue_op(qpr_pkg::FUNC_ROTATE, -32768, -32768, -32768, -32768,
             -32768, -32768, -32768, -32768);
    queue_op(qpr_pkg::FUNC_ROTATE, 0, -32768, 0, 0, 0, -32768, -32768, 32767);
    queue_op(qpr_pkg::FUNC_ROTATE, 0, 0, 0, 0, -32768, 0, 0, 0);
    queue_op(qpr_pkg::FUNC_ROTATE, 1, 1, 1, 1, 32767, -32768, 32767, -32768);
    queue_op(qpr_pkg::FUNC_ROTATE, 16'sh5555, -16'sh5556, 16'sh5555, -16'sh5556,
             -16'sh5556, 16'sh5555, -16'sh5556, 16'sh5555);
    repeat (N_RANDOM) op_q.push_back(rand_op());
    n_total = op_q.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // wait until every queued item has come back as a result
    while (n_out < n_total) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (quat_due_q.size() != 0) begin
      $error("%0d predicted results never arrived", quat_due_q.size());
      errs++;
    end
    $display("run covered %0d input transfers (%0d rotations) and %0d results,",
             n_in, n_rot, n_out);
    $display("%0d of them saturated, with bursty input and a long output hold-off", n_sat);
    if (errs == 0) begin
      $display("quaternion_product_rotate_unit_core: match");
    end else begin
      $display("quaternion_product_rotate_unit_core: mismatch");
    end
    $finish;
  end

endmodule
